>>> design/hrhp_pkg.sv
package hrhp_pkg;

	// line parser phases
	typedef enum logic [2:0] {
		PH_PREFIX  = 3'd0,
		PH_VERSION = 3'd1,
		PH_SPACES  = 3'd2,
		PH_CODE    = 3'd3,
		PH_SKIP    = 3'd4,
		PH_NAME    = 3'd5,
		PH_VALWS   = 3'd6,
		PH_VALDIG  = 3'd7
	} phase_t;

	// result status codes
	localparam logic [2:0] ST_OK          = 3'd0;
	localparam logic [2:0] ST_BAD_VERSION = 3'd1;
	localparam logic [2:0] ST_NO_SPACE    = 3'd2;
	localparam logic [2:0] ST_BAD_CODE    = 3'd3;
	localparam logic [2:0] ST_JUNK        = 3'd4;
	localparam logic [2:0] ST_TOO_LONG    = 3'd5;

	// character constants
	localparam logic [7:0] CH_CR    = 8'h0d;
	localparam logic [7:0] CH_LF    = 8'h0a;
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_COLON = 8'h3a;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	localparam logic [3:0] PREFIX_LEN = 4'd5;
	localparam logic [3:0] NAME_LEN   = 4'd14;
	localparam logic [3:0] COL_MAX    = 4'd15;

	// result field widths and packing
	localparam int STATUS_W = 3;
	localparam int CODE_W   = 16;
	localparam int LEN_W    = 32;
	localparam int HDR_W    = 14;
	localparam int OUT_W    = STATUS_W + CODE_W + LEN_W + HDR_W;
	localparam int OUT_TW   = ((OUT_W + 7) / 8) * 8;

	// per-line parse state
	typedef struct packed {
		phase_t             phase;
		logic [3:0]         column;
		logic               mismatch;
		logic [CODE_W-1:0]  code;
		logic [LEN_W-1:0]   len;
		logic [STATUS_W-1:0] err;
	} pst_t;

	function automatic logic [7:0] prefix_char(input logic [3:0] i);
		case (i)
			4'd0: prefix_char = 8'h48; // H
			4'd1: prefix_char = 8'h54; // T
			4'd2: prefix_char = 8'h54; // T
			4'd3: prefix_char = 8'h50; // P
			4'd4: prefix_char = 8'h2f; // /
			default: prefix_char = 8'hff;
		endcase
	endfunction

	// lower-case content-length
	function automatic logic [7:0] name_char(input logic [3:0] i);
		case (i)
			4'd0: name_char = 8'h63;
			4'd1: name_char = 8'h6f;
			4'd2: name_char = 8'h6e;
			4'd3: name_char = 8'h74;
			4'd4: name_char = 8'h65;
			4'd5: name_char = 8'h6e;
			4'd6: name_char = 8'h74;
			4'd7: name_char = 8'h2d;
			4'd8: name_char = 8'h6c;
			4'd9: name_char = 8'h65;
			4'd10: name_char = 8'h6e;
			4'd11: name_char = 8'h67;
			4'd12: name_char = 8'h74;
			4'd13: name_char = 8'h68;
			default: name_char = 8'hff;
		endcase
	endfunction

	function automatic logic [7:0] lower_ascii(input logic [7:0] c);
		lower_ascii = (c >= 8'h41 && c <= 8'h5a) ? c + 8'd32 : c;
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

	// one character of a line
	function automatic pst_t feed_char(input pst_t s, input logic [7:0] c);
		pst_t r;
		logic [3:0] d;
		logic [CODE_W+3:0] cv;
		logic [LEN_W+3:0] lv;
		r = s;
		d = c[3:0] - CH_ZERO[3:0];
		cv = {s.code, 3'b0} + {2'b0, s.code, 1'b0} + {{CODE_W{1'b0}}, d};
		lv = {s.len, 3'b0} + {2'b0, s.len, 1'b0} + {{LEN_W{1'b0}}, d};
		case (s.phase)
			PH_PREFIX: begin
				if (s.column < PREFIX_LEN && c == prefix_char(s.column)) begin
					r.column = s.column + 4'd1;
					if (s.column == PREFIX_LEN - 4'd1)
						r.phase = PH_VERSION;
				end else begin
					r.err = ST_BAD_VERSION;
				end
			end
			PH_VERSION: begin
				if (c == CH_SP)
					r.phase = PH_SPACES;
			end
			PH_SPACES: begin
				if (c != CH_SP) begin
					if (is_digit(c)) begin
						r.code = {{(CODE_W-4){1'b0}}, d};
						r.phase = PH_CODE;
					end else begin
						r.err = ST_BAD_CODE;
					end
				end
			end
			PH_CODE: begin
				if (is_digit(c))
					r.code = (cv[CODE_W+3:CODE_W] != 4'd0) ? {CODE_W{1'b1}} : cv[CODE_W-1:0];
				else if (c == CH_SP)
					r.phase = PH_SKIP;
				else
					r.err = ST_JUNK;
			end
			PH_NAME: begin
				if (c == CH_COLON) begin
					r.phase = (!s.mismatch && s.column == NAME_LEN) ? PH_VALWS : PH_SKIP;
				end else begin
					if (!(s.column < NAME_LEN && lower_ascii(c) == name_char(s.column)))
						r.mismatch = 1'b1;
					if (s.column < COL_MAX)
						r.column = s.column + 4'd1;
				end
			end
			PH_VALWS: begin
				if (c != CH_SP && c != CH_TAB) begin
					if (is_digit(c)) begin
						r.len = {{(LEN_W-4){1'b0}}, d};
						r.phase = PH_VALDIG;
					end else begin
						r.phase = PH_SKIP;
					end
				end
			end
			PH_VALDIG: begin
				if (is_digit(c))
					r.len = (lv[LEN_W+3:LEN_W] != 4'd0) ? {LEN_W{1'b1}} : lv[LEN_W-1:0];
				else
					r.phase = PH_SKIP;
			end
			default: ;
		endcase
		return r;
	endfunction

	// line end: status line errors or start of a header line
	function automatic pst_t end_line(input pst_t s);
		pst_t r;
		r = s;
		case (s.phase)
			PH_PREFIX:  r.err = ST_BAD_VERSION;
			PH_VERSION: r.err = ST_NO_SPACE;
			PH_SPACES:  r.err = ST_BAD_CODE;
			default: begin
				r.phase = PH_NAME;
				r.column = 4'd0;
				r.mismatch = 1'b0;
			end
		endcase
		return r;
	endfunction

endpackage

>>> design/http_response_header_parser_unit.sv
// HTTP response header parser. Takes the response one byte per transfer on the
// s_ side (s_tuser high on the first byte of a response clears all parse state)
// and gives one result on the m_ side when the header ends at LF LF or LF CR LF,
// or when MAX_HEADER bytes pass without an end. One byte is taken every cycle
// while the result register is free; a result is registered in the result register
// when the byte that caused it moves on from the input register. The rate is set by
// the update of the parse state, which sits between the input register and the result
// register. Bytes after a result are taken and dropped until the next first byte.
module http_response_header_parser_unit import hrhp_pkg::*; #(
	parameter int MAX_HEADER = 8192
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [7:0]        s_tdata,   // data_byte
	input  logic              s_tuser,   // first_byte
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [OUT_TW-1:0] m_tdata    // parse_status, status_code, content_length,
	                                     // header_bytes, zero fill
);

	localparam int CW = $clog2(MAX_HEADER + 1);

	// input stage
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       first_s1;

	// parse state
	pst_t       pst_q;
	logic       pcr_q;
	logic       stopped_q;
	logic       finished_q;
	logic [1:0] ed_q;
	logic [CW-1:0] bc_q;

	// result register
	logic              out_valid_q;
	logic [OUT_TW-1:0] out_data_q;

	// next state
	pst_t          pst_n;
	logic          pcr_n;
	logic          stopped_n;
	logic          finished_n;
	logic [1:0]    ed_n;
	logic [CW-1:0] bc_n;
	logic          emit;
	logic          done;
	logic          too_long;
	logic          take;
	logic [OUT_TW-1:0] result;
	logic [CW+HDR_W-1:0] bc_ext;

	logic out_busy;
	logic adv;

	assign out_busy = out_valid_q && !m_tready;
	assign adv      = valid_s1 && !out_busy;
	assign s_tready = !valid_s1 || !out_busy;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1  <= s_tdata;
			first_s1 <= s_tuser;
		end
	end

	// byte step: next parse state
	always_comb begin
		pst_n      = pst_q;
		pcr_n      = pcr_q;
		stopped_n  = stopped_q;
		finished_n = finished_q;
		ed_n       = ed_q;
		bc_n       = bc_q;
		done       = 1'b0;
		too_long   = 1'b0;
		take       = 1'b1;
		if (first_s1) begin
			pst_n.phase    = PH_PREFIX;
			pst_n.column   = 4'd0;
			pst_n.mismatch = 1'b0;
			pst_n.code     = '0;
			pst_n.len      = '0;
			pst_n.err      = ST_OK;
			pcr_n          = 1'b0;
			stopped_n      = 1'b0;
			finished_n     = 1'b0;
			ed_n           = 2'd0;
			bc_n           = '0;
		end
		if (!finished_n) begin
			bc_n = bc_n + {{(CW-1){1'b0}}, 1'b1};
			// interpretation of the byte
			if (!stopped_n && pst_n.err == ST_OK) begin
				if (pcr_n) begin
					pcr_n = 1'b0;
					if (byte_s1 == CH_LF) begin
						pst_n = end_line(pst_n);
						take = 1'b0;
					end else begin
						pst_n = feed_char(pst_n, CH_CR);
						if (pst_n.err != ST_OK)
							take = 1'b0;
					end
				end
				if (take) begin
					if (byte_s1 == CH_CR) begin
						pcr_n = 1'b1;
					end else if (byte_s1 == CH_LF) begin
						pst_n = end_line(pst_n);
					end else if (byte_s1 == CH_NUL) begin
						pst_n = end_line(pst_n);
						stopped_n = 1'b1;
					end else begin
						pst_n = feed_char(pst_n, byte_s1);
					end
				end
			end
			// header end search
			if (byte_s1 == CH_LF) begin
				done = (ed_n != 2'd0);
				ed_n = 2'd1;
			end else if (byte_s1 == CH_CR) begin
				ed_n = (ed_n == 2'd1) ? 2'd2 : 2'd0;
			end else begin
				ed_n = 2'd0;
			end
			too_long = !done && (bc_n >= CW'(MAX_HEADER));
			finished_n = done || too_long;
		end
	end

	// result fields
	assign bc_ext = {{HDR_W{1'b0}}, bc_n};
	assign emit   = done || too_long;

	always_comb begin
		result = '0;
		if (too_long) begin
			result[STATUS_W-1:0] = ST_TOO_LONG;
		end else begin
			result[STATUS_W-1:0] = pst_n.err;
			if (pst_n.err == ST_OK) begin
				result[STATUS_W +: CODE_W]        = pst_n.code;
				result[STATUS_W+CODE_W +: LEN_W]  = pst_n.len;
			end
			result[STATUS_W+CODE_W+LEN_W +: HDR_W] = bc_ext[HDR_W-1:0];
		end
	end

	// parse state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pst_q.phase    <= PH_PREFIX;
			pst_q.column   <= 4'd0;
			pst_q.mismatch <= 1'b0;
			pst_q.code     <= '0;
			pst_q.len      <= '0;
			pst_q.err      <= ST_OK;
			pcr_q          <= 1'b0;
			stopped_q      <= 1'b0;
			finished_q     <= 1'b0;
			ed_q           <= 2'd0;
			bc_q           <= '0;
		end else if (adv) begin
			pst_q      <= pst_n;
			pcr_q      <= pcr_n;
			stopped_q  <= stopped_n;
			finished_q <= finished_n;
			ed_q       <= ed_n;
			bc_q       <= bc_n;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && emit)
			out_data_q <= result;
	end

	// checks
	a_err_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[STATUS_W-1:0] != ST_OK |->
		m_tdata[STATUS_W+CODE_W+LEN_W-1:STATUS_W] == '0)
		else $error("error result carries a code or a length");

	a_too_long_no_offset: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[STATUS_W-1:0] == ST_TOO_LONG |->
		m_tdata[STATUS_W+CODE_W+LEN_W +: HDR_W] == '0)
		else $error("header too long result carries a body offset");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		bc_q <= CW'(MAX_HEADER))
		else $error("byte count passed the header limit");

	a_result_ends_parse: assert property (@(posedge clk) disable iff (!arst_n)
		adv && emit |=> finished_q)
		else $error("result given without ending the response");

endmodule

>>> dv/tb_http_response_header_parser_unit.sv
`timescale 1ns / 100ps

module tb_http_response_header_parser_unit;
	import hrhp_pkg::*;

	localparam int HDR_LIMIT   = 8192;
	localparam int ITEMS       = 1500;
	localparam int QUIET_LIMIT = 4000;

	// one parse result as packed on m_tdata, parse_status in the low bits
	typedef struct packed {
		logic [HDR_W-1:0]    header_bytes;
		logic [LEN_W-1:0]    content_length;
		logic [CODE_W-1:0]   status_code;
		logic [STATUS_W-1:0] parse_status;
	} header_result_t;

	// header parser prediction and result checking
	class header_scoreboard;
		phase_t          phase;
		int unsigned     column;
		bit              name_bad;
		bit              cr_held;
		bit              stopped;
		bit              finished;
		logic [1:0]      end_seen;
		int unsigned     count;
		int unsigned     code_acc;
		longint unsigned len_acc;
		logic [2:0]      err;
		header_result_t  expected_headers[$];
		int              mismatches;
		int              results_predicted;
		string           prefix_text = "HTTP/";
		string           name_text = "content-length";

		function new();
			clear();
			mismatches = 0;
			results_predicted = 0;
		endfunction

		function void clear();
			phase = PH_PREFIX;
			column = 0;
			name_bad = 1'b0;
			cr_held = 1'b0;
			stopped = 1'b0;
			finished = 1'b0;
			end_seen = 2'd0;
			count = 0;
			code_acc = 0;
			len_acc = 0;
			err = ST_OK;
		endfunction

		// one character of the current line
		function void take_char(input logic [7:0] c);
			logic [7:0] lc;
			bit digit;
			lc = (c >= 8'h41 && c <= 8'h5a) ? c + 8'd32 : c;
			digit = (c >= CH_ZERO && c <= CH_NINE);
			case (phase)
				PH_PREFIX: begin
					if (column < prefix_text.len() && c == prefix_text[column]) begin
						column++;
						if (column == prefix_text.len())
							phase = PH_VERSION;
					end else begin
						err = ST_BAD_VERSION;
					end
				end
				PH_VERSION: begin
					if (c == CH_SP)
						phase = PH_SPACES;
				end
				PH_SPACES: begin
					if (c != CH_SP) begin
						if (digit) begin
							code_acc = c - CH_ZERO;
							phase = PH_CODE;
						end else begin
							err = ST_BAD_CODE;
						end
					end
				end
				PH_CODE: begin
					if (digit) begin
						code_acc = code_acc * 10 + (c - CH_ZERO);
						if (code_acc > 65535)
							code_acc = 65535;
					end else if (c == CH_SP) begin
						phase = PH_SKIP;
					end else begin
						err = ST_JUNK;
					end
				end
				PH_NAME: begin
					if (c == CH_COLON) begin
						phase = (!name_bad && column == name_text.len()) ? PH_VALWS : PH_SKIP;
					end else begin
						if (!(column < name_text.len() && lc == name_text[column]))
							name_bad = 1'b1;
						if (column < 15)
							column++;
					end
				end
				PH_VALWS: begin
					if (c != CH_SP && c != CH_TAB) begin
						if (digit) begin
							len_acc = c - CH_ZERO;
							phase = PH_VALDIG;
						end else begin
							phase = PH_SKIP;
						end
					end
				end
				PH_VALDIG: begin
					if (digit) begin
						len_acc = len_acc * 10 + (c - CH_ZERO);
						if (len_acc > 64'hFFFF_FFFF)
							len_acc = 64'hFFFF_FFFF;
					end else begin
						phase = PH_SKIP;
					end
				end
				default: ;
			endcase
		endfunction

		// line end: status line errors, else start of a header line
		function void close_line();
			case (phase)
				PH_PREFIX:  err = ST_BAD_VERSION;
				PH_VERSION: err = ST_NO_SPACE;
				PH_SPACES:  err = ST_BAD_CODE;
				default: begin
					phase = PH_NAME;
					column = 0;
					name_bad = 1'b0;
				end
			endcase
		endfunction

		// line splitting, held cr and the zero byte
		function void interpret_byte(input logic [7:0] b);
			if (cr_held) begin
				cr_held = 1'b0;
				if (b == CH_LF) begin
					close_line();
					return;
				end
				take_char(CH_CR);
				if (err != ST_OK)
					return;
			end
			if (b == CH_CR) begin
				cr_held = 1'b1;
			end else if (b == CH_LF) begin
				close_line();
			end else if (b == CH_NUL) begin
				close_line();
				stopped = 1'b1;
			end else begin
				take_char(b);
			end
		endfunction

		// one accepted byte; returns 1 when it completes a result
		function bit parse_byte(input logic [7:0] b, input bit first,
				output header_result_t res);
			bit done;
			done = 1'b0;
			res = '0;
			if (first)
				clear();
			if (finished)
				return 1'b0;
			count++;
			if (!stopped && err == ST_OK)
				interpret_byte(b);
			// header end detection on raw bytes
			if (b == CH_LF) begin
				done = (end_seen != 2'd0);
				end_seen = 2'd1;
			end else if (b == CH_CR) begin
				end_seen = (end_seen == 2'd1) ? 2'd2 : 2'd0;
			end else begin
				end_seen = 2'd0;
			end
			if (done) begin
				finished = 1'b1;
				res.parse_status = err;
				res.status_code = (err == ST_OK) ? code_acc[CODE_W-1:0] : '0;
				res.content_length = (err == ST_OK) ? len_acc[LEN_W-1:0] : '0;
				res.header_bytes = count[HDR_W-1:0];
				return 1'b1;
			end
			if (count >= HDR_LIMIT) begin
				finished = 1'b1;
				res.parse_status = ST_TOO_LONG;
				return 1'b1;
			end
			return 1'b0;
		endfunction

		function void note_byte(input logic [7:0] b, input bit first);
			header_result_t res;
			if (parse_byte(b, first, res)) begin
				expected_headers.push_back(res);
				results_predicted++;
			end
		endfunction

		function int pending();
			return expected_headers.size();
		endfunction

		task report(input string msg);
			mismatches++;
			if (mismatches <= 100)
				$display("[%0t] mismatch: %s", $time, msg);
		endtask

		task check_result(input logic [OUT_TW-1:0] d);
			header_result_t got;
			header_result_t want;
			got = d[OUT_W-1:0];
			if (d[OUT_TW-1:OUT_W] != '0)
				report($sformatf("fill bits not zero in %h", d));
			if (expected_headers.size() == 0) begin
				report($sformatf("result %h with none expected", d));
				return;
			end
			want = expected_headers.pop_front();
			if (got.parse_status != want.parse_status)
				report($sformatf("parse_status %0d, expected %0d",
					got.parse_status, want.parse_status));
			if (got.status_code != want.status_code)
				report($sformatf("status_code %0d, expected %0d",
					got.status_code, want.status_code));
			if (got.content_length != want.content_length)
				report($sformatf("content_length %0d, expected %0d",
					got.content_length, want.content_length));
			if (got.header_bytes != want.header_bytes)
				report($sformatf("header_bytes %0d, expected %0d",
					got.header_bytes, want.header_bytes));
		endtask
	endclass

	logic              clk;
	logic              arst_n = 1'b0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [7:0]        s_tdata = 8'h00;
	logic              s_tuser = 1'b0;
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [OUT_TW-1:0] m_tdata;

	header_scoreboard sb = new();
	logic [7:0]       resp_bytes[$];
	bit               idle_on = 1'b1;
	bit               stim_busy = 1'b0;
	int               hold_left = 0;

	http_response_header_parser_unit #(.MAX_HEADER(HDR_LIMIT)) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// result side: check transfers, stall in random bursts
	always @(posedge clk) begin
		if (m_tvalid && m_tready)
			sb.check_result(m_tdata);
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else if (idle_on && $urandom_range(0, 9) == 0) begin
			hold_left = $urandom_range(0, 17);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// end the run when nothing moves while work is outstanding
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
					(!stim_busy && sb.pending() == 0))
				quiet = 0;
			else
				quiet++;
		end
		$display("FAIL");
		$finish;
	end

	// one byte transfer, with an optional idle burst ahead of it
	task automatic send_byte(input logic [7:0] b, input bit first);
		if (idle_on && $urandom_range(0, 7) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tuser  <= first;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sb.note_byte(b, first);
	endtask

	task automatic send_response(input bit first);
		foreach (resp_bytes[i])
			send_byte(resp_bytes[i], first && i == 0);
	endtask

	task automatic add_text(input string s);
		for (int i = 0; i < s.len(); i++)
			resp_bytes.push_back(s[i]);
	endtask

	task automatic run_text(input string s, input bit first);
		resp_bytes.delete();
		add_text(s);
		send_response(first);
	endtask

	task automatic add_line_end();
		if ($urandom_range(0, 9) < 7)
			add_text("\r\n");
		else
			add_text("\n");
	endtask

	task automatic add_digits(input int n);
		repeat (n)
			resp_bytes.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
	endtask

	task automatic add_printable(input int n);
		repeat (n)
			resp_bytes.push_back(8'($urandom_range(8'h21, 8'h7e)));
	endtask

	// one header line: half the time content-length in mixed case, else some other field
	task automatic add_header_line();
		logic [7:0] c;
		int kind;
		string nm;
		kind = $urandom_range(0, 9);
		nm = "content-length";
		if (kind < 5) begin
			for (int i = 0; i < nm.len(); i++) begin
				c = nm[i];
				if (c >= 8'h61 && c <= 8'h7a && $urandom_range(0, 1))
					c = c - 8'd32;
				resp_bytes.push_back(c);
			end
			// near misses on the name
			if (kind == 0)
				case ($urandom_range(0, 2))
					0: resp_bytes.push_back(8'h68);
					1: void'(resp_bytes.pop_back());
					default: resp_bytes[resp_bytes.size() - 1 - $urandom_range(0, 13)] = 8'h71;
				endcase
			resp_bytes.push_back(CH_COLON);
			repeat ($urandom_range(0, 2))
				resp_bytes.push_back($urandom_range(0, 1) ? CH_SP : CH_TAB);
			if ($urandom_range(0, 7) == 0)
				add_text("x");
			add_digits($urandom_range(0, 7) == 0 ? $urandom_range(7, 12)
				: $urandom_range(1, 6));
			if ($urandom_range(0, 5) == 0)
				add_text(" ;q");
		end else begin
			repeat ($urandom_range(1, 16))
				resp_bytes.push_back($urandom_range(0, 7) == 0 ? 8'h2d
					: 8'($urandom_range(8'h41, 8'h5a)));
			add_text(": ");
			add_printable($urandom_range(0, 12));
		end
		add_line_end();
	endtask

	// random response: mostly well formed, some noise and broken ones
	task automatic build_random_response();
		int kind;
		int cut;
		resp_bytes.delete();
		kind = $urandom_range(0, 99);
		if (kind < 8) begin
			repeat ($urandom_range(1, 40))
				resp_bytes.push_back(8'($urandom_range(0, 255)));
			if ($urandom_range(0, 1))
				add_text("\n\n");
			return;
		end
		// status line
		if (kind < 11)
			add_text("HTTP");
		else
			add_text("HTTP/");
		repeat ($urandom_range(0, 4))
			resp_bytes.push_back($urandom_range(0, 3) == 0 ? 8'h2e
				: 8'(CH_ZERO + $urandom_range(0, 9)));
		repeat (kind < 14 ? 0 : ($urandom_range(0, 4) == 0 ? $urandom_range(2, 3) : 1))
			resp_bytes.push_back(CH_SP);
		add_digits(kind < 17 ? 0 : ($urandom_range(0, 5) == 0 ? $urandom_range(4, 6) : 3));
		if ($urandom_range(0, 2) != 0) begin
			resp_bytes.push_back(CH_SP);
			add_printable($urandom_range(0, 10));
		end
		add_line_end();
		repeat ($urandom_range(0, 4))
			add_header_line();
		add_line_end();
		// broken ones: corrupted bytes, a zero byte or a cut-off tail
		if (kind >= 82) begin
			repeat ($urandom_range(1, 3))
				resp_bytes[$urandom_range(0, resp_bytes.size() - 1)] =
					8'($urandom_range(0, 255));
		end
		if (kind >= 90 && kind < 95)
			resp_bytes[$urandom_range(0, resp_bytes.size() - 1)] = CH_NUL;
		if (kind >= 95) begin
			cut = $urandom_range(1, resp_bytes.size());
			while (resp_bytes.size() > cut)
				void'(resp_bytes.pop_back());
		end
	endtask

	initial begin
		int rand_bytes;
		int result_goal;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		stim_busy = 1'b1;

		// directed: first response straight from reset
		run_text("HTTP/1.1 200 OK\r\nContent-Length: 42\r\n\r\n", 1'b0);
		run_text("HTTP/1.0 404\n\n", 1'b1);
		run_text({"HTTP/1.1   301 Moved\r\nCONTENT-length:\t 7\r\n",
			"content-LENGTH: 99\r\nServer: x\r\n\n"}, 1'b1);
		run_text("http/1.1 200 OK\r\n\r\n", 1'b1);
		run_text("HTTP/1.1\r\n\r\n", 1'b1);
		run_text("HTTP/1.1 abc\r\n\r\n", 1'b1);
		run_text("HTTP/1.1 20x OK\r\n\r\n", 1'b1);
		run_text("HTTP/1.1 200\tOK\n\n", 1'b1);
		run_text("HTTP/1.1    \n\n", 1'b1);
		run_text("HTTP/1.1 9999999 Big\nContent-Length: 123456789012345\n\n", 1'b1);
		run_text({"HTTP/1.1 0\nContent-Length: 4294967295\n",
			"Content-Length: 4294967296\n\n"}, 1'b1);
		run_text({"HTTP/1.1 200 OK\nContent-Length: x12\nContent-Lengthx: 5\n",
			"content-length-and-more: 6\nContent-Length:   \n\n"}, 1'b1);
		run_text("HTTP/1.1 200 OK\nContent-Length: 3\r4\r\n\n", 1'b1);
		// cr pairs and lf cr cr lf do not end the header
		run_text("HTTP/1.1 204 No\r\r\nContent-Length:12\n\r\r\nX: 1\n\r\n", 1'b1);
		run_text("\r\n\r\n", 1'b1);

		// zero byte mid header, at the start, and after a cr
		resp_bytes.delete();
		add_text("HTTP/1.1 200 OK\r\nContent-Length: 5");
		resp_bytes.push_back(CH_NUL);
		add_text("Content-Length: 9\r\n\r\n");
		send_response(1'b1);
		resp_bytes.delete();
		resp_bytes.push_back(CH_NUL);
		add_text("\n\n");
		send_response(1'b1);
		resp_bytes.delete();
		add_text("HTTP/1.1 200\r");
		resp_bytes.push_back(CH_NUL);
		add_text("\n\n");
		send_response(1'b1);

		// restart mid header, then bytes after a result are dropped
		run_text("HTTP/1.1 200\nContent-Le", 1'b1);
		run_text("HTTP/1.1 500 E\n\n", 1'b1);
		run_text("HTTP/1.1 200 OK\n\nbody\n\n", 1'b1);
		run_text("HTTP/1.1 201 X\n\n", 1'b0);

		// header too long
		resp_bytes.delete();
		add_text("HTTP/1.1 200 OK\r\n");
		while (resp_bytes.size() < HDR_LIMIT + 3)
			resp_bytes.push_back(8'h61);
		send_response(1'b1);

		// terminator completes on the last allowed byte
		resp_bytes.delete();
		add_text("HTTP/1.1 200 OK\nX:");
		while (resp_bytes.size() < HDR_LIMIT - 2)
			resp_bytes.push_back(8'h62);
		add_text("\n\n");
		send_response(1'b1);

		// random responses with random idling
		rand_bytes = 0;
		result_goal = sb.results_predicted + 48;
		while (rand_bytes < ITEMS || sb.results_predicted < result_goal) begin
			idle_on = ($urandom_range(0, 3) != 0);
			build_random_response();
			rand_bytes += resp_bytes.size();
			send_response($urandom_range(0, 19) != 0);
			// body bytes after the header
			if ($urandom_range(0, 6) == 0) begin
				resp_bytes.delete();
				add_printable($urandom_range(1, 10));
				send_response(1'b0);
			end
		end

		// last stretch at full rate on both sides
		idle_on = 1'b0;
		repeat (10) begin
			build_random_response();
			send_response(1'b1);
		end
		s_tvalid <= 1'b0;
		stim_busy = 1'b0;

		while (sb.pending() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (sb.pending() != 0)
			sb.report($sformatf("%0d results never arrived", sb.pending()));

		if (sb.mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
